// ----- rtl/dsmp_pkg.sv -----
// shared types and constants of the diagonal-scaled matrix projection block
package dsmp_pkg;

   localparam int DIM_W   = 6;
   localparam int IDX_W   = 5;
   localparam int VAL_W   = 16;
   localparam int RES_W   = 32;
   localparam int PROD1_W = 2 * VAL_W;
   localparam int PROD2_W = PROD1_W + VAL_W;
   localparam int ACC_W   = PROD2_W + DIM_W;
   localparam int SHIFT   = 24;
   localparam int DIM_CAP = 32;

   localparam logic [1:0] CMD_LOAD_Z = 2'd0;
   localparam logic [1:0] CMD_LOAD_D = 2'd1;
   localparam logic [1:0] CMD_COLUMN = 2'd2;

   localparam logic CSR_ROWS_USED  = 1'b0;
   localparam logic CSR_INNER_USED = 1'b1;

   typedef struct packed {
      logic valid;
      logic clear;
   } mac_ctl_type;

endpackage

// ----- rtl/diag_scaled_matrix_projection.sv -----
// top level: command decode, stores, sequencer and result register
//
// channel | dir | transfer when          | payload
// req     | in  | req_tvalid & req_tready | tuser cmd, tdata row/inner index and value
// rsp     | out | rsp_tvalid & rsp_tready | tdata result and row, tlast on final row
// csr     | in  | csr_we                  | index and write data
//
// a completing column element starts, for each row in turn, one shared multiply-accumulate
// pass over the row's inner elements, a drain of the product pipeline and one result load
// loads and other elements are taken while idle; req_tready is low during the pass
// reset is synchronous; the stores are not cleared and hold what was written
// a stalled rsp side holds the pass at the end of a row until the result moves
module diag_scaled_matrix_projection #(
   parameter int ROWS_MAX  = 32,
   parameter int INNER_MAX = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,  // row_index, inner_index, value
   input  logic [1:0]                   req_tuser,  // cmd
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,  // result, out_row
   output logic                         rsp_tlast,  // last
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [dsmp_pkg::DIM_W-1:0]   csr_wdata
);
   import dsmp_pkg::*;

   localparam int ZD      = ROWS_MAX * INNER_MAX;
   localparam int ZAW     = (ZD > 1) ? $clog2(ZD) : 1;
   localparam int IW      = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int RW      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int ROW_LIM = (ROWS_MAX < DIM_CAP) ? ROWS_MAX : DIM_CAP;
   localparam int INN_LIM = (INNER_MAX < DIM_CAP) ? INNER_MAX : DIM_CAP;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_PUT   = 2'd3;

   logic signed [VAL_W-1:0] z_mem [ZD];
   logic signed [VAL_W-1:0] d_mem [INNER_MAX];
   logic signed [VAL_W-1:0] b_mem [INNER_MAX];

   logic [DIM_W-1:0]        rows_ff, rows_in;
   logic [DIM_W-1:0]        inner_ff, inner_in;
   logic [1:0]              state_ff, state_in;
   logic [IW-1:0]           i_ff, i_in;
   logic [RW-1:0]           j_ff, j_in;
   logic                    rd_valid_ff;
   logic signed [VAL_W-1:0] z_rd_ff, d_rd_ff, b_rd_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [RES_W-1:0]        out_result_ff;
   logic [IDX_W-1:0]        out_row_ff;
   logic                    out_last_ff;

   logic [1:0]              cmd;
   logic [IDX_W-1:0]        row_idx;
   logic [IDX_W-1:0]        inner_idx;
   logic signed [VAL_W-1:0] value;
   logic [DIM_W-1:0]        rows_eff, inner_eff;
   logic                    accept, z_we, d_we, b_we, start;
   logic                    i_last, j_last, load;
   mac_ctl_type             mac_ctl;
   logic                    mac_busy;
   logic signed [RES_W-1:0] mac_result;

   assign cmd       = req_tuser;
   assign row_idx   = req_tdata[4:0];
   assign inner_idx = req_tdata[9:5];
   assign value     = req_tdata[25:10];

   always_comb begin
      rows_eff = rows_ff;
      if (rows_ff == '0) begin
         rows_eff = DIM_W'(1);
      end else if (rows_ff > DIM_W'(ROW_LIM)) begin
         rows_eff = DIM_W'(ROW_LIM);
      end
      inner_eff = inner_ff;
      if (inner_ff == '0) begin
         inner_eff = DIM_W'(1);
      end else if (inner_ff > DIM_W'(INN_LIM)) begin
         inner_eff = DIM_W'(INN_LIM);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign z_we  = accept && (cmd == CMD_LOAD_Z) && (32'(row_idx) < ROWS_MAX)
                  && (32'(inner_idx) < INNER_MAX);
   assign d_we  = accept && (cmd == CMD_LOAD_D) && (32'(inner_idx) < INNER_MAX);
   assign b_we  = accept && (cmd == CMD_COLUMN) && (DIM_W'(inner_idx) < inner_eff);
   assign start = b_we && (DIM_W'(inner_idx) == inner_eff - DIM_W'(1));

   assign i_last = (DIM_W'(i_ff) == inner_eff - DIM_W'(1));
   assign j_last = (DIM_W'(j_ff) == rows_eff - DIM_W'(1));
   assign load   = (state_ff == ST_PUT) && (!out_valid_ff || rsp_tready);

   // stores
   always_ff @(posedge clock) begin
      if (z_we) begin
         z_mem[ZAW'(32'(row_idx) * INNER_MAX + 32'(inner_idx))] <= value;
      end
      z_rd_ff <= z_mem[ZAW'(32'(j_ff) * INNER_MAX + 32'(i_ff))];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         d_mem[IW'(inner_idx)] <= value;
      end
      d_rd_ff <= d_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[IW'(inner_idx)] <= value;
      end
      b_rd_ff <= b_mem[i_ff];
   end

   // configuration
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_USED:  rows_in  = csr_wdata;
            CSR_INNER_USED: inner_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_RUN: begin
            if (i_last) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (load) begin
               i_in = '0;
               if (j_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  j_in     = j_ff + RW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_W'(DIM_CAP);
         inner_ff     <= DIM_W'(DIM_CAP);
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         inner_ff     <= inner_in;
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rd_valid_ff  <= (state_ff == ST_RUN);
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_result_ff <= mac_result;
         out_row_ff    <= IDX_W'(j_ff);
         out_last_ff   <= j_last;
      end
   end

   assign mac_ctl.valid = rd_valid_ff;
   assign mac_ctl.clear = load || start;

   dsmp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .z_val  (z_rd_ff),
      .d_val  (d_rd_ff),
      .b_val  (b_rd_ff),
      .busy   (mac_busy),
      .result (mac_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_row_ff, out_result_ff};
   assign rsp_tlast  = out_last_ff;

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      load |-> (!mac_busy && !rd_valid_ff))
      else $error("row result loaded while products still in flight");

   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!mac_busy && !rd_valid_ff))
      else $error("input ready while accumulation still running");

   a_last_row_ends: assert property (@(posedge clock) disable iff (reset)
      (load && j_last) |=> (req_tready && rsp_tvalid && rsp_tlast))
      else $error("final row did not return sequencer to idle");

endmodule

// ----- rtl/dsmp_mac.sv -----
// pipelined triple-product multiply-accumulate unit with floor shift
module dsmp_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dsmp_pkg::mac_ctl_type                ctl,
   input  logic signed [dsmp_pkg::VAL_W-1:0]    z_val,
   input  logic signed [dsmp_pkg::VAL_W-1:0]    d_val,
   input  logic signed [dsmp_pkg::VAL_W-1:0]    b_val,
   output logic                                 busy,
   output logic signed [dsmp_pkg::RES_W-1:0]    result
);
   import dsmp_pkg::*;

   localparam int SH_W = ACC_W - SHIFT;

   logic                      v1_ff, v1_in;
   logic                      v2_ff, v2_in;
   logic signed [PROD1_W-1:0] p1_ff, p1_in;
   logic signed [VAL_W-1:0]   b1_ff, b1_in;
   logic signed [PROD2_W-1:0] p2_ff, p2_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SH_W-1:0]    shifted;

   always_comb begin
      v1_in = ctl.valid;
      v2_in = v1_ff;
      p1_in = z_val * d_val;
      b1_in = b_val;
      p2_in = p1_ff * b1_ff;
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(p2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      b1_ff  <= b1_in;
      p2_ff  <= p2_in;
      acc_ff <= acc_in;
   end

   // floor shift; the shifted sum of 32 terms always fits in 32 bits
   assign shifted = SH_W'(acc_ff >>> SHIFT);
   assign result  = RES_W'(shifted);
   assign busy    = v1_ff | v2_ff;

endmodule
